@@ src/rtp_depacketizer_stream_defines.svh @@
`ifndef RTP_DEPACKETIZER_STREAM_DEFINES_SVH
`define RTP_DEPACKETIZER_STREAM_DEFINES_SVH

// Same-cycle implication, masked while reset is low.
`define RTPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtpd: same-cycle check failed");

// Next-cycle implication, masked while reset is low.
`define RTPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtpd: next-cycle check failed");

`endif

@@ src/rtpd_pkg.sv @@
package rtpd_pkg;

    localparam int unsigned CfgAddrWidth = 5;

    localparam logic [2:0] REG_PT_H264       = 3'd0;
    localparam logic [2:0] REG_PT_FEC_SOURCE = 3'd1;
    localparam logic [2:0] REG_PT_FEC_REPAIR = 3'd2;
    localparam logic [2:0] REG_PT_AV1        = 3'd3;
    localparam logic [2:0] REG_PT_OPUS       = 3'd4;
    localparam logic [2:0] REG_PT_DATA       = 3'd5;

    localparam logic [6:0] PT_H264_RST       = 7'd96;
    localparam logic [6:0] PT_FEC_SOURCE_RST = 7'd97;
    localparam logic [6:0] PT_FEC_REPAIR_RST = 7'd98;
    localparam logic [6:0] PT_AV1_RST        = 7'd99;
    localparam logic [6:0] PT_OPUS_RST       = 7'd111;
    localparam logic [6:0] PT_DATA_RST       = 7'd127;

    localparam logic [2:0] CLS_H264       = 3'd0;
    localparam logic [2:0] CLS_FU_A       = 3'd1;
    localparam logic [2:0] CLS_FEC_SOURCE = 3'd2;
    localparam logic [2:0] CLS_FEC_REPAIR = 3'd3;
    localparam logic [2:0] CLS_AV1        = 3'd4;
    localparam logic [2:0] CLS_OPUS       = 3'd5;
    localparam logic [2:0] CLS_DATA       = 3'd6;
    localparam logic [2:0] CLS_UNKNOWN    = 3'd7;

    localparam logic [4:0] NAL_TYPE_FU_A = 5'd28;
    localparam logic [3:0] FIXED_HDR_LAST = 4'd11;

    typedef enum logic [5:0] {
        PH_FIXED   = 6'b000001,
        PH_CSRC    = 6'b000010,
        PH_EXTHDR  = 6'b000100,
        PH_EXTBODY = 6'b001000,
        PH_FORMAT  = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [6:0] pt_h264;
        logic [6:0] pt_fec_source;
        logic [6:0] pt_fec_repair;
        logic [6:0] pt_av1;
        logic [6:0] pt_opus;
        logic [6:0] pt_data;
    } t_cfg;

    typedef struct packed {
        logic        marker;
        logic [6:0]  ptype;
        logic [15:0] seq;
        logic [31:0] ts;
        logic [31:0] ssrc;
        logic [2:0]  cls;
        logic [7:0]  fmt;
        logic [7:0]  fu;
        logic [15:0] fec;
    } t_held;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_last;
        logic       status;
        t_held      held;
    } t_result;

    function automatic logic [2:0] classify(input t_cfg cfg, input logic [6:0] pt);
        logic [2:0] cls;
        if (pt == cfg.pt_h264) begin
            cls = CLS_H264;
        end else if (pt == cfg.pt_fec_source) begin
            cls = CLS_FEC_SOURCE;
        end else if (pt == cfg.pt_fec_repair) begin
            cls = CLS_FEC_REPAIR;
        end else if (pt == cfg.pt_av1) begin
            cls = CLS_AV1;
        end else if (pt == cfg.pt_opus) begin
            cls = CLS_OPUS;
        end else if (pt == cfg.pt_data) begin
            cls = CLS_DATA;
        end else begin
            cls = CLS_UNKNOWN;
        end
        return cls;
    endfunction

endpackage

@@ src/rtpd_parser.sv @@
module rtpd_parser
    import rtpd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  t_cfg       i_cfg,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_idx, n_idx;
    logic [17:0] r_skip, n_skip;
    logic [3:0]  r_csrc, n_csrc;
    logic        r_ext, n_ext;
    t_held       r_held, n_held;

    logic [17:0] skip_dec;

    function automatic t_phase fmt_phase(input logic [2:0] cls);
        return (cls <= CLS_AV1) ? PH_FORMAT : PH_PAYLOAD;
    endfunction

    assign skip_dec = (r_skip != '0) ? 18'(r_skip - 18'd1) : r_skip;

    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_skip      = r_skip;
        n_csrc      = r_csrc;
        n_ext       = r_ext;
        n_held      = r_held;
        o_res_valid = 1'b0;
        o_res.payload_byte = i_data_byte;
        o_res.payload_last = i_last_byte;
        o_res.status       = 1'b0;

        if (i_accept) begin
            if (r_phase == PH_PAYLOAD) begin
                o_res_valid = 1'b1;
                if (i_last_byte) begin
                    n_phase = PH_FIXED;
                    n_idx   = '0;
                end
            end else begin
                case (r_phase)
                    PH_FIXED: begin
                        if (r_idx == 4'd0) begin
                            n_held     = '0;
                            n_held.cls = CLS_UNKNOWN;
                            n_csrc     = i_data_byte[3:0];
                            n_ext      = i_data_byte[4];
                        end else if (r_idx == 4'd1) begin
                            n_held.marker = i_data_byte[7];
                            n_held.ptype  = i_data_byte[6:0];
                            n_held.cls    = classify(i_cfg, i_data_byte[6:0]);
                        end else if (r_idx <= 4'd3) begin
                            n_held.seq = {r_held.seq[7:0], i_data_byte};
                        end else if (r_idx <= 4'd7) begin
                            n_held.ts = {r_held.ts[23:0], i_data_byte};
                        end else begin
                            n_held.ssrc = {r_held.ssrc[23:0], i_data_byte};
                        end
                        if (r_idx >= FIXED_HDR_LAST) begin
                            n_idx = '0;
                            if (r_csrc != '0) begin
                                n_phase = PH_CSRC;
                                n_skip  = {12'd0, r_csrc, 2'b00};
                            end else if (r_ext) begin
                                n_phase = PH_EXTHDR;
                            end else begin
                                n_phase = fmt_phase(r_held.cls);
                            end
                        end else begin
                            n_idx = 4'(r_idx + 4'd1);
                        end
                    end
                    PH_CSRC: begin
                        n_skip = skip_dec;
                        if (skip_dec == '0) begin
                            n_idx   = '0;
                            n_phase = r_ext ? PH_EXTHDR : fmt_phase(r_held.cls);
                        end
                    end
                    PH_EXTHDR: begin
                        // length word is big endian; body is 4 bytes per unit
                        if (r_idx == 4'd2) begin
                            n_skip = {2'b00, i_data_byte, 8'd0};
                        end else if (r_idx == 4'd3) begin
                            n_skip = {r_skip[15:8], i_data_byte, 2'b00};
                        end
                        if (r_idx >= 4'd3) begin
                            n_idx   = '0;
                            n_phase = (n_skip != '0) ? PH_EXTBODY : fmt_phase(r_held.cls);
                        end else begin
                            n_idx = 4'(r_idx + 4'd1);
                        end
                    end
                    PH_EXTBODY: begin
                        n_skip = skip_dec;
                        if (skip_dec == '0) begin
                            n_idx   = '0;
                            n_phase = fmt_phase(r_held.cls);
                        end
                    end
                    PH_FORMAT: begin
                        if (r_held.cls == CLS_H264 || r_held.cls == CLS_FU_A) begin
                            if (r_idx == 4'd0) begin
                                n_held.fmt = i_data_byte;
                                if (i_data_byte[4:0] == NAL_TYPE_FU_A) begin
                                    n_held.cls = CLS_FU_A;
                                    n_idx      = 4'd1;
                                end else begin
                                    n_phase = PH_PAYLOAD;
                                end
                            end else begin
                                n_held.fu = i_data_byte;
                                n_phase   = PH_PAYLOAD;
                            end
                        end else if (r_held.cls == CLS_FEC_SOURCE ||
                                     r_held.cls == CLS_FEC_REPAIR) begin
                            if (r_idx <= 4'd1) begin
                                n_held.fec = {r_held.fec[7:0], i_data_byte};
                            end else if (r_held.cls == CLS_FEC_SOURCE) begin
                                if (r_idx == 4'd2) begin
                                    n_held.fmt = i_data_byte;
                                end else begin
                                    n_held.fu = i_data_byte;
                                end
                            end
                            if (r_idx >= 4'd3) begin
                                n_phase = PH_PAYLOAD;
                            end else begin
                                n_idx = 4'(r_idx + 4'd1);
                            end
                        end else begin
                            n_held.fmt = i_data_byte;
                            n_phase    = PH_PAYLOAD;
                        end
                    end
                    default: begin
                        n_phase = PH_FIXED;
                        n_idx   = '0;
                    end
                endcase

                // packet ended inside the headers: flag it and restart
                if (i_last_byte) begin
                    o_res_valid        = 1'b1;
                    o_res.payload_byte = '0;
                    o_res.payload_last = 1'b1;
                    o_res.status       = 1'b1;
                    n_phase            = PH_FIXED;
                    n_idx              = '0;
                    n_skip             = '0;
                end
            end
        end
        o_res.held = n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIXED;
            r_idx   <= '0;
            r_skip  <= '0;
            r_csrc  <= '0;
            r_ext   <= 1'b0;
            r_held  <= '0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_skip  <= n_skip;
            r_csrc  <= n_csrc;
            r_ext   <= n_ext;
            r_held  <= n_held;
        end
    end

endmodule

@@ src/rtpd_out_buf.sv @@
module rtpd_out_buf
    import rtpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    input  logic    i_out_stall,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid, n_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_res, n_res;
    t_result r_skid, n_skid;

    assign o_full  = r_skid_valid;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_valid      = r_valid;
        n_skid_valid = r_skid_valid;
        n_res        = r_res;
        n_skid       = r_skid;
        if (!r_valid || !i_out_stall) begin
            // output slot frees up: drain the skid entry first
            if (r_skid_valid) begin
                n_res        = r_skid;
                n_valid      = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_res   = i_res;
                n_valid = i_res_valid;
            end
        end else if (i_res_valid) begin
            n_skid       = i_res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_valid      <= n_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_skid <= n_skid;
    end

endmodule

@@ src/rtp_depacketizer_stream.sv @@
// RTP depacketizer, one packet byte per item.
// Input channel: i_in_valid / o_in_stall carry i_data_byte and i_last_byte, with
// i_last_byte set on the final byte of each packet. Header bytes (fixed header,
// CSRC list, extension, format header) are absorbed; each payload byte leaves on
// the output channel (o_out_valid / i_out_stall) with the captured header fields.
// A packet that ends inside its headers yields one item with o_status = 1,
// o_payload_last = 1 and o_payload_byte = 0.
// Each result is registered before it is presented on the output channel.
// Throughput: one byte per cycle while o_in_stall is low; the parser advances on every accepted byte.
// A result that meets a stalled output register parks in a skid register, and
// o_in_stall is that register's full flag: the input pauses until the skid item
// moves to the output, so a sustained stall backs up to the input after one
// extra item.
// Payload type numbers are set over the APB port (one register per word) and
// should be written only while no packet is in flight.
// Reset (synchronous, active low) returns the parser to the start of a packet,
// empties the output buffer and restores the default payload type numbers.
module rtp_depacketizer_stream
    import rtpd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [7:0]              i_data_byte,
    input  logic                    i_last_byte,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [7:0]              o_payload_byte,
    output logic                    o_payload_last,
    output logic                    o_status,
    output logic [2:0]              o_packet_class,
    output logic                    o_marker_bit,
    output logic [6:0]              o_payload_type,
    output logic [15:0]             o_sequence_number,
    output logic [31:0]             o_timestamp,
    output logic [31:0]             o_ssrc,
    output logic [7:0]              o_format_header,
    output logic [7:0]              o_fu_header,
    output logic [15:0]             o_fec_fields,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CfgAddrWidth-1:0] paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    t_cfg       r_cfg;
    logic       cfg_wr;
    logic [2:0] cfg_sel;
    logic       in_accept;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_sel = paddr[CfgAddrWidth-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pt_h264       <= PT_H264_RST;
            r_cfg.pt_fec_source <= PT_FEC_SOURCE_RST;
            r_cfg.pt_fec_repair <= PT_FEC_REPAIR_RST;
            r_cfg.pt_av1        <= PT_AV1_RST;
            r_cfg.pt_opus       <= PT_OPUS_RST;
            r_cfg.pt_data       <= PT_DATA_RST;
        end else if (cfg_wr) begin
            case (cfg_sel)
                REG_PT_H264:       r_cfg.pt_h264       <= pwdata[6:0];
                REG_PT_FEC_SOURCE: r_cfg.pt_fec_source <= pwdata[6:0];
                REG_PT_FEC_REPAIR: r_cfg.pt_fec_repair <= pwdata[6:0];
                REG_PT_AV1:        r_cfg.pt_av1        <= pwdata[6:0];
                REG_PT_OPUS:       r_cfg.pt_opus       <= pwdata[6:0];
                REG_PT_DATA:       r_cfg.pt_data       <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            REG_PT_H264:       prdata = {25'd0, r_cfg.pt_h264};
            REG_PT_FEC_SOURCE: prdata = {25'd0, r_cfg.pt_fec_source};
            REG_PT_FEC_REPAIR: prdata = {25'd0, r_cfg.pt_fec_repair};
            REG_PT_AV1:        prdata = {25'd0, r_cfg.pt_av1};
            REG_PT_OPUS:       prdata = {25'd0, r_cfg.pt_opus};
            REG_PT_DATA:       prdata = {25'd0, r_cfg.pt_data};
            default:           prdata = '0;
        endcase
    end

    assign in_accept = i_in_valid & ~o_in_stall;

    rtpd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    rtpd_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_out_stall (i_out_stall),
        .o_full      (o_in_stall),
        .o_valid     (o_out_valid),
        .o_res       (out_res)
    );

    assign o_payload_byte    = out_res.payload_byte;
    assign o_payload_last    = out_res.payload_last;
    assign o_status          = out_res.status;
    assign o_packet_class    = out_res.held.cls;
    assign o_marker_bit      = out_res.held.marker;
    assign o_payload_type    = out_res.held.ptype;
    assign o_sequence_number = out_res.held.seq;
    assign o_timestamp       = out_res.held.ts;
    assign o_ssrc            = out_res.held.ssrc;
    assign o_format_header   = out_res.held.fmt;
    assign o_fu_header       = out_res.held.fu;
    assign o_fec_fields      = out_res.held.fec;

endmodule

@@ src/rtpd_checker.sv @@
`include "rtp_depacketizer_stream_defines.svh"

module rtpd_checker
    import rtpd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_payload_byte,
    input logic        o_payload_last,
    input logic        o_status,
    input logic [2:0]  o_packet_class,
    input logic [15:0] o_sequence_number,
    input logic [31:0] o_ssrc,
    input logic [7:0]  o_fu_header,
    input logic [15:0] o_fec_fields
);

    logic        out_waiting;
    logic [55:0] out_key;
    logic        flag_out;
    logic        flag_ok;
    logic        fu_out;
    logic        fu_ok;
    logic        fec_out;
    logic        fec_ok;

    assign out_waiting = o_out_valid && i_out_stall;
    assign out_key     = {o_payload_byte, o_sequence_number, o_ssrc};
    assign flag_out    = o_out_valid && o_status;
    assign flag_ok     = o_payload_last && (o_payload_byte == 8'd0);
    assign fu_out      = o_out_valid && (o_fu_header != 8'd0);
    assign fu_ok       = (o_packet_class == CLS_FU_A) || (o_packet_class == CLS_FEC_SOURCE);
    assign fec_out     = o_out_valid && (o_fec_fields != 16'd0);
    assign fec_ok      = (o_packet_class == CLS_FEC_SOURCE) ||
                         (o_packet_class == CLS_FEC_REPAIR);

    // a stalled result holds until taken
    `RTPD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_waiting, o_out_valid && $stable(out_key))

    // an early-end flag always closes the packet
    `RTPD_ASSERT_NOW(a_flag_last, i_clk, i_rst_n, flag_out, flag_ok)

    // only FU-A and FEC source packets carry an FU header
    `RTPD_ASSERT_NOW(a_fu_class, i_clk, i_rst_n, fu_out, fu_ok)

    // FEC fields appear only on FEC classes
    `RTPD_ASSERT_NOW(a_fec_class, i_clk, i_rst_n, fec_out, fec_ok)

endmodule

bind rtp_depacketizer_stream rtpd_checker u_rtpd_checker (.*);

@@ tb/sv/rtp_depacketizer_stream_tb.sv @@
module rtp_depacketizer_stream_tb;
    import rtpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } t_pkt_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [CfgAddrWidth-1:0] paddr = '0;
    logic [31:0] pwdata = 32'h0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_payload_byte;
    logic        o_payload_last;
    logic        o_status;
    logic [2:0]  o_packet_class;
    logic        o_marker_bit;
    logic [6:0]  o_payload_type;
    logic [15:0] o_sequence_number;
    logic [31:0] o_timestamp;
    logic [31:0] o_ssrc;
    logic [7:0]  o_format_header;
    logic [7:0]  o_fu_header;
    logic [15:0] o_fec_fields;
    logic [31:0] prdata;
    logic        pready;

    rtp_depacketizer_stream dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_data_byte       (i_data_byte),
        .i_last_byte       (i_last_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_payload_byte    (o_payload_byte),
        .o_payload_last    (o_payload_last),
        .o_status          (o_status),
        .o_packet_class    (o_packet_class),
        .o_marker_bit      (o_marker_bit),
        .o_payload_type    (o_payload_type),
        .o_sequence_number (o_sequence_number),
        .o_timestamp       (o_timestamp),
        .o_ssrc            (o_ssrc),
        .o_format_header   (o_format_header),
        .o_fu_header       (o_fu_header),
        .o_fec_fields      (o_fec_fields),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // Parser state mirrored by the predictor
    t_phase      parse_ph = PH_FIXED;
    logic [3:0]  hdr_idx = 4'd0;
    logic [17:0] skip_left = 18'd0;
    logic [3:0]  csrc_cnt = 4'd0;
    logic        ext_flag = 1'b0;
    t_held       held_now = '0;
    t_cfg        cfg_now = '{PT_H264_RST, PT_FEC_SOURCE_RST, PT_FEC_REPAIR_RST,
                             PT_AV1_RST, PT_OPUS_RST, PT_DATA_RST};

    t_pkt_byte   packet_bytes_q[$];
    t_result     expected_payloads[$];
    int          queued_count = 0;
    int          mismatch_count = 0;
    int          results_seen = 0;

    // Traffic shaping knobs
    bit          sender_bursty = 1'b1;
    int          stall_mode = 1;
    int          holds_asked = 0;
    int          holds_granted = 0;
    int          hold_left = 0;
    int          gap_left = 0;
    int          burst_left = 0;
    logic [15:0] stall_bits = 16'h0;
    logic [3:0]  pattern_pos = 4'd0;

    logic        sender_busy;
    t_pkt_byte   next_item;
    t_result     want;
    t_result     seen;
    t_result     oldest;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic void begin_format();
        hdr_idx = 4'd0;
        parse_ph = (held_now.cls <= CLS_AV1) ? PH_FORMAT : PH_PAYLOAD;
    endfunction

    function automatic void after_csrc();
        hdr_idx = 4'd0;
        if (ext_flag) begin
            parse_ph = PH_EXTHDR;
        end else begin
            begin_format();
        end
    endfunction

    // Advance the parser by one packet byte; returns 1 when the byte yields a result.
    function automatic bit depacketize_byte(input logic [7:0] b, input logic fin,
                                            output t_result res);
        res = '0;
        if (parse_ph == PH_PAYLOAD) begin
            res.payload_byte = b;
            res.payload_last = fin;
            res.status = 1'b0;
            res.held = held_now;
            if (fin) begin
                parse_ph = PH_FIXED;
                hdr_idx = 4'd0;
            end
            return 1'b1;
        end
        case (parse_ph)
            PH_FIXED: begin
                if (hdr_idx == 4'd0) begin
                    held_now = '0;
                    held_now.cls = CLS_UNKNOWN;
                    csrc_cnt = b[3:0];
                    ext_flag = b[4];
                end else if (hdr_idx == 4'd1) begin
                    held_now.marker = b[7];
                    held_now.ptype = b[6:0];
                    // first matching register wins
                    if (b[6:0] == cfg_now.pt_h264) begin
                        held_now.cls = CLS_H264;
                    end else if (b[6:0] == cfg_now.pt_fec_source) begin
                        held_now.cls = CLS_FEC_SOURCE;
                    end else if (b[6:0] == cfg_now.pt_fec_repair) begin
                        held_now.cls = CLS_FEC_REPAIR;
                    end else if (b[6:0] == cfg_now.pt_av1) begin
                        held_now.cls = CLS_AV1;
                    end else if (b[6:0] == cfg_now.pt_opus) begin
                        held_now.cls = CLS_OPUS;
                    end else if (b[6:0] == cfg_now.pt_data) begin
                        held_now.cls = CLS_DATA;
                    end else begin
                        held_now.cls = CLS_UNKNOWN;
                    end
                end else if (hdr_idx <= 4'd3) begin
                    held_now.seq = {held_now.seq[7:0], b};
                end else if (hdr_idx <= 4'd7) begin
                    held_now.ts = {held_now.ts[23:0], b};
                end else begin
                    held_now.ssrc = {held_now.ssrc[23:0], b};
                end
                if (hdr_idx >= FIXED_HDR_LAST) begin
                    if (csrc_cnt != 4'd0) begin
                        parse_ph = PH_CSRC;
                        hdr_idx = 4'd0;
                        skip_left = {12'd0, csrc_cnt, 2'b00};
                    end else begin
                        after_csrc();
                    end
                end else begin
                    hdr_idx = hdr_idx + 4'd1;
                end
            end
            PH_CSRC: begin
                if (skip_left != 18'd0) skip_left = skip_left - 18'd1;
                if (skip_left == 18'd0) after_csrc();
            end
            PH_EXTHDR: begin
                // extension length counts 32-bit words
                if (hdr_idx == 4'd2) begin
                    skip_left = {2'b00, b, 8'h00};
                end else if (hdr_idx == 4'd3) begin
                    skip_left = {skip_left[15:0] | {8'h00, b}, 2'b00};
                end
                if (hdr_idx >= 4'd3) begin
                    hdr_idx = 4'd0;
                    if (skip_left != 18'd0) begin
                        parse_ph = PH_EXTBODY;
                    end else begin
                        begin_format();
                    end
                end else begin
                    hdr_idx = hdr_idx + 4'd1;
                end
            end
            PH_EXTBODY: begin
                if (skip_left != 18'd0) skip_left = skip_left - 18'd1;
                if (skip_left == 18'd0) begin_format();
            end
            PH_FORMAT: begin
                if (held_now.cls == CLS_H264 || held_now.cls == CLS_FU_A) begin
                    if (hdr_idx == 4'd0) begin
                        held_now.fmt = b;
                        if (b[4:0] == NAL_TYPE_FU_A) begin
                            held_now.cls = CLS_FU_A;
                            hdr_idx = 4'd1;
                        end else begin
                            parse_ph = PH_PAYLOAD;
                        end
                    end else begin
                        held_now.fu = b;
                        parse_ph = PH_PAYLOAD;
                    end
                end else if (held_now.cls == CLS_FEC_SOURCE ||
                             held_now.cls == CLS_FEC_REPAIR) begin
                    if (hdr_idx <= 4'd1) begin
                        held_now.fec = {held_now.fec[7:0], b};
                    end else if (held_now.cls == CLS_FEC_SOURCE) begin
                        if (hdr_idx == 4'd2) begin
                            held_now.fmt = b;
                        end else begin
                            held_now.fu = b;
                        end
                    end
                    if (hdr_idx >= 4'd3) begin
                        parse_ph = PH_PAYLOAD;
                    end else begin
                        hdr_idx = hdr_idx + 4'd1;
                    end
                end else begin
                    held_now.fmt = b;
                    parse_ph = PH_PAYLOAD;
                end
            end
            default: begin
                parse_ph = PH_FIXED;
                hdr_idx = 4'd0;
            end
        endcase
        if (fin) begin
            // packet ended inside its headers
            res.payload_byte = 8'h00;
            res.payload_last = 1'b1;
            res.status = 1'b1;
            res.held = held_now;
            parse_ph = PH_FIXED;
            hdr_idx = 4'd0;
            skip_left = 18'd0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic add_packet(input logic [6:0] pt, input int n_csrc, input bit ext_on,
                              input logic [15:0] ext_len, input int body_len,
                              input bit fua, input int cut);
        logic [7:0] pkt[$];
        logic [7:0] rnd;
        t_pkt_byte  one;
        int total;
        rnd = 8'($urandom);
        pkt.insert(pkt.size(), {rnd[7:5], ext_on, 4'(n_csrc)});
        rnd = 8'($urandom);
        pkt.insert(pkt.size(), {rnd[7], pt});
        repeat (10 + 4 * n_csrc) pkt.insert(pkt.size(), 8'($urandom));
        if (ext_on) begin
            pkt.insert(pkt.size(), 8'($urandom));
            pkt.insert(pkt.size(), 8'($urandom));
            pkt.insert(pkt.size(), ext_len[15:8]);
            pkt.insert(pkt.size(), ext_len[7:0]);
            // stop building once past the cut point
            for (int k = 0; k < 4 * int'(ext_len) && (cut == 0 || pkt.size() < cut); k++) begin
                pkt.insert(pkt.size(), 8'($urandom));
            end
        end
        for (int k = 0; k < body_len; k++) begin
            rnd = 8'($urandom);
            if (k == 0 && fua) rnd[4:0] = NAL_TYPE_FU_A;
            pkt.insert(pkt.size(), rnd);
        end
        total = (cut > 0 && cut < pkt.size()) ? cut : pkt.size();
        for (int k = 0; k < total; k++) begin
            one.data = pkt[k];
            one.fin = (k == total - 1);
            packet_bytes_q.insert(packet_bytes_q.size(), one);
        end
        queued_count += total;
    endtask

    task automatic add_flat_packet(input int len, input logic [7:0] value);
        t_pkt_byte one;
        for (int k = 0; k < len; k++) begin
            one.data = value;
            one.fin = (k == len - 1);
            packet_bytes_q.insert(packet_bytes_q.size(), one);
        end
        queued_count += len;
    endtask

    task automatic add_random_traffic(input int n_bytes);
        int target;
        int n_csrc;
        int body_len;
        int cut;
        logic [6:0] pt;
        logic [15:0] ext_len;
        bit ext_on;
        bit fua;
        target = queued_count + n_bytes;
        while (queued_count < target) begin
            case ($urandom_range(0, 7))
                0: pt = cfg_now.pt_h264;
                1: pt = cfg_now.pt_fec_source;
                2: pt = cfg_now.pt_fec_repair;
                3: pt = cfg_now.pt_av1;
                4: pt = cfg_now.pt_opus;
                5: pt = cfg_now.pt_data;
                default: pt = 7'($urandom);
            endcase
            n_csrc = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 15)) : 0;
            ext_on = ($urandom_range(0, 3) == 0);
            ext_len = 16'($urandom_range(0, 3));
            cut = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 40)) : 0;
            if (ext_on && $urandom_range(0, 9) == 0) begin
                // random extension length, with a cut point of 13 to 60 bytes
                ext_len = 16'($urandom);
                cut = $urandom_range(13, 60);
            end
            body_len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 4))
                                                   : int'($urandom_range(5, 30));
            fua = ($urandom_range(0, 2) == 0);
            add_packet(pt, n_csrc, ext_on, ext_len, body_len, fua, cut);
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
        if (got_val !== exp_val) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("result %0d: %s expected %h got %h", results_seen, what,
                         exp_val, got_val);
            end
        end
    endtask

    task automatic write_pt(input logic [2:0] reg_idx, input logic [6:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= {25'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (reg_idx)
            REG_PT_H264:       cfg_now.pt_h264 = value;
            REG_PT_FEC_SOURCE: cfg_now.pt_fec_source = value;
            REG_PT_FEC_REPAIR: cfg_now.pt_fec_repair = value;
            REG_PT_AV1:        cfg_now.pt_av1 = value;
            REG_PT_OPUS:       cfg_now.pt_opus = value;
            REG_PT_DATA:       cfg_now.pt_data = value;
            default: ;
        endcase
        // read the register back while the address still points at it
        @(posedge i_clk);
        check_field("readback", {25'd0, value}, prdata);
    endtask

    task automatic set_all_pts(input t_cfg c);
        write_pt(REG_PT_H264, c.pt_h264);
        write_pt(REG_PT_FEC_SOURCE, c.pt_fec_source);
        write_pt(REG_PT_FEC_REPAIR, c.pt_fec_repair);
        write_pt(REG_PT_AV1, c.pt_av1);
        write_pt(REG_PT_OPUS, c.pt_opus);
        write_pt(REG_PT_DATA, c.pt_data);
    endtask

    // Wait until every queued byte is in and every result is out.
    task automatic wait_drained();
        while (packet_bytes_q.size() != 0 || i_in_valid || expected_payloads.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Sender: bursts with random gaps when sender_bursty is set, item held while stalled
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            sender_busy = i_in_valid && o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                if (depacketize_byte(i_data_byte, i_last_byte, want)) begin
                    expected_payloads.insert(expected_payloads.size(), want);
                end
            end
            if (!sender_busy) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (packet_bytes_q.size() > 0) begin
                    next_item = packet_bytes_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_data_byte <= next_item.data;
                    i_last_byte <= next_item.fin;
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(0, 40);
                        if (sender_bursty) gap_left <= $urandom_range(1, 8);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: long hold-off on request, else a rotating stall pattern
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (holds_granted != holds_asked) begin
            holds_granted <= holds_granted + 1;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            pattern_pos <= pattern_pos + 4'd1;
            if (pattern_pos == 4'd15) begin
                case (stall_mode)
                    0: stall_bits <= 16'h0000;
                    1: stall_bits <= 16'($urandom & $urandom);
                    2: stall_bits <= 16'($urandom | $urandom);
                    default: stall_bits <= 16'($urandom);
                endcase
            end
            i_out_stall <= stall_bits[pattern_pos];
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            seen.payload_byte = o_payload_byte;
            seen.payload_last = o_payload_last;
            seen.status = o_status;
            seen.held.marker = o_marker_bit;
            seen.held.ptype = o_payload_type;
            seen.held.seq = o_sequence_number;
            seen.held.ts = o_timestamp;
            seen.held.ssrc = o_ssrc;
            seen.held.cls = o_packet_class;
            seen.held.fmt = o_format_header;
            seen.held.fu = o_fu_header;
            seen.held.fec = o_fec_fields;
            if (expected_payloads.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("result %0d: unexpected item, payload byte %h", results_seen,
                             o_payload_byte);
                end
            end else begin
                oldest = expected_payloads.pop_front();
                check_field("payload_byte", 32'(oldest.payload_byte),
                            32'(seen.payload_byte));
                check_field("payload_last", 32'(oldest.payload_last),
                            32'(seen.payload_last));
                check_field("status", 32'(oldest.status), 32'(seen.status));
                check_field("packet_class", 32'(oldest.held.cls), 32'(seen.held.cls));
                check_field("marker_bit", 32'(oldest.held.marker), 32'(seen.held.marker));
                check_field("pt_number", 32'(oldest.held.ptype), 32'(seen.held.ptype));
                check_field("sequence_number", 32'(oldest.held.seq), 32'(seen.held.seq));
                check_field("timestamp", oldest.held.ts, seen.held.ts);
                check_field("ssrc", oldest.held.ssrc, seen.held.ssrc);
                check_field("format_header", 32'(oldest.held.fmt), 32'(seen.held.fmt));
                check_field("fu_header", 32'(oldest.held.fu), 32'(seen.held.fu));
                check_field("fec_fields", 32'(oldest.held.fec), 32'(seen.held.fec));
            end
        end
    end

    initial begin
        t_cfg pts;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed packets with default payload type numbers
        sender_bursty = 1'b1;
        stall_mode = 1;
        add_packet(7'd96, 0, 1'b0, 16'd0, 4, 1'b0, 0);
        add_packet(7'd96, 0, 1'b0, 16'd0, 5, 1'b1, 0);
        add_packet(7'd97, 0, 1'b0, 16'd0, 7, 1'b0, 0);
        add_packet(7'd98, 0, 1'b0, 16'd0, 6, 1'b0, 0);
        add_packet(7'd99, 0, 1'b0, 16'd0, 3, 1'b0, 0);
        add_packet(7'd111, 0, 1'b0, 16'd0, 3, 1'b0, 0);
        add_packet(7'd127, 0, 1'b0, 16'd0, 2, 1'b0, 0);
        add_packet(7'd5, 0, 1'b0, 16'd0, 2, 1'b0, 0);
        add_packet(7'd96, 15, 1'b1, 16'd2, 3, 1'b0, 0);
        add_packet(7'd111, 1, 1'b1, 16'd0, 1, 1'b0, 0);
        add_packet(7'd127, 0, 1'b1, 16'h0040, 2, 1'b0, 0);
        add_packet(7'd99, 0, 1'b1, 16'hFFFF, 2, 1'b0, 40);
        add_packet(7'd96, 0, 1'b0, 16'd0, 4, 1'b0, 1);
        add_packet(7'd96, 0, 1'b0, 16'd0, 4, 1'b0, 2);
        add_packet(7'd111, 0, 1'b0, 16'd0, 0, 1'b0, 0);
        add_packet(7'd97, 2, 1'b0, 16'd0, 5, 1'b0, 15);
        add_packet(7'd98, 0, 1'b1, 16'd3, 5, 1'b0, 14);
        add_packet(7'd97, 0, 1'b0, 16'd0, 5, 1'b0, 14);
        add_packet(7'd96, 0, 1'b0, 16'd0, 1, 1'b1, 13);
        add_packet(7'd96, 0, 1'b0, 16'd0, 1, 1'b0, 0);
        add_flat_packet(20, 8'h00);
        add_flat_packet(80, 8'hFF);
        wait_drained();

        // long receiver hold-off against a steady sender
        sender_bursty = 1'b0;
        stall_mode = 0;
        holds_asked++;
        add_random_traffic(250);
        wait_drained();

        sender_bursty = 1'b1;
        stall_mode = 2;
        set_all_pts('0);
        add_random_traffic(200);
        wait_drained();

        sender_bursty = 1'b0;
        stall_mode = 1;
        set_all_pts('{7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F});
        add_random_traffic(200);
        wait_drained();

        sender_bursty = 1'b1;
        stall_mode = 3;
        pts = '0;
        pts.pt_h264 = 7'($urandom);
        pts.pt_fec_source = 7'($urandom);
        pts.pt_fec_repair = 7'($urandom);
        pts.pt_av1 = 7'($urandom);
        pts.pt_opus = 7'($urandom);
        pts.pt_data = 7'($urandom);
        set_all_pts(pts);
        add_random_traffic(300);
        wait_drained();

        // overlapping numbers exercise match priority
        stall_mode = 1;
        pts.pt_h264 = 7'(96 + $urandom_range(0, 2));
        pts.pt_fec_source = 7'(96 + $urandom_range(0, 2));
        pts.pt_fec_repair = 7'(96 + $urandom_range(0, 2));
        pts.pt_av1 = 7'(96 + $urandom_range(0, 2));
        pts.pt_opus = 7'(96 + $urandom_range(0, 2));
        pts.pt_data = 7'(96 + $urandom_range(0, 2));
        set_all_pts(pts);
        add_random_traffic(270);
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_payloads.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
